// File: sv/u8u16_pkg.sv
package u8u16_pkg;

  localparam int BYTE_W = 8;
  localparam int UNIT_W = 16;
  localparam int CP_W = 21;
  localparam int JOB_CPS = 3;
  localparam int CNT_W = 2;
  localparam int IDX_W = 2;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // follow byte counts of a lead, with the invalid marker
  localparam logic [2:0] FOLLOW_NONE = 3'd0;
  localparam logic [2:0] FOLLOW_ONE = 3'd1;
  localparam logic [2:0] FOLLOW_TWO = 3'd2;
  localparam logic [2:0] FOLLOW_THREE = 3'd3;
  localparam logic [2:0] FOLLOW_BAD = 3'd4;

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;
  localparam logic [UNIT_W-1:0] HI_SURR = 16'hD800;
  localparam logic [UNIT_W-1:0] LO_SURR = 16'hDC00;

  // one queued job: up to three code points made by one input byte
  typedef struct packed {
    logic [JOB_CPS-1:0][CP_W-1:0] cps;
    logic [CNT_W-1:0]             cnt;
    logic                         last;
  } job_t;

  function automatic logic [2:0] follow_count(input logic [BYTE_W-1:0] c);
    logic [2:0] f;
    begin
      if (c[7] == 1'b0) f = FOLLOW_NONE;
      else if (c[7:5] == 3'b110) f = FOLLOW_ONE;
      else if (c[7:4] == 4'b1110) f = FOLLOW_TWO;
      else if (c[7:3] == 5'b11110) f = FOLLOW_THREE;
      else f = FOLLOW_BAD;
      return f;
    end
  endfunction

  // a byte decoded on its own: ascii passes, anything else is replaced
  function automatic logic [CP_W-1:0] single_cp(input logic [BYTE_W-1:0] c);
    logic [CP_W-1:0] cp;
    begin
      if (c[7] == 1'b0) cp = {{(CP_W-BYTE_W){1'b0}}, c};
      else cp = REPL_CP;
      return cp;
    end
  endfunction

endpackage

// File: sv/utf8_to_utf16_transcoder_unit.sv
// utf-8 bytes in, utf-16 code units out, one byte accepted per cycle while the job queue is not full
// path: the accepting edge writes the job queue, and the first unit of that byte is then
// registered onto the output from the queue head once the output register is free
// throughput: one byte per cycle in while the queue has room, one code unit per cycle out while
// the receiver is ready; a byte that makes 2 or 3 units holds the queue head, the 2-entry job queue absorbs it
// reset: synchronous active-high rst empties the queue and the open sequence, no clearing pass
module utf8_to_utf16_transcoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [u8u16_pkg::BYTE_W-1:0]  s_axis_tdata,  // in_byte
  input  logic                          s_axis_tlast,  // stream_last
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [u8u16_pkg::UNIT_W-1:0]  m_axis_tdata,  // code_unit
  output logic                          m_axis_tlast,  // run_last
  output logic                          m_axis_tuser   // stream_end
);
  import u8u16_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  job_t q_in;
  job_t q_head;

  u8u16_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_in)
  );

  u8u16_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head)
  );

  u8u16_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_valid),
    .head_job      (q_head),
    .pop           (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: sv/u8u16_front.sv
module u8u16_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [u8u16_pkg::BYTE_W-1:0]  s_axis_tdata,  // in_byte
  input  logic                          s_axis_tlast,  // stream_last
  input  logic                          q_full,
  output logic                          q_push,
  output u8u16_pkg::job_t               q_job
);
  import u8u16_pkg::*;

  logic [BYTE_W-1:0] held0, held1, held2;
  logic [1:0]        held_count;
  logic [1:0]        needed_total;

  logic              accept;
  logic [2:0]        f_in;
  logic [2:0]        f_h1;
  logic              job_valid;
  logic              open_seq;
  logic              finish;
  logic              complete;
  logic              start;
  job_t              job;

  assign s_axis_tready = !q_full;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign f_in = follow_count(s_axis_tdata);
  assign f_h1 = follow_count(held1);
  assign open_seq = (needed_total != 2'd0);
  assign complete = (held_count >= needed_total);
  assign finish = open_seq && (complete || s_axis_tlast);
  assign start = !open_seq && !s_axis_tlast &&
                 (f_in == FOLLOW_ONE || f_in == FOLLOW_TWO || f_in == FOLLOW_THREE);

  always_comb begin
    job.cps = '0;
    job.cnt = 2'd1;
    job.last = s_axis_tlast;
    job_valid = 1'b0;
    if (!open_seq) begin
      job_valid = !start;
      job.cps[0] = single_cp(s_axis_tdata);
    end else if (finish) begin
      job_valid = 1'b1;
      if (complete) begin
        case (needed_total)
          2'd1: job.cps[0] = {10'b0, held0[4:0], s_axis_tdata[5:0]};
          2'd2: job.cps[0] = {5'b0, held0[3:0], held1[5:0], s_axis_tdata[5:0]};
          default: job.cps[0] = {held0[2:0], held1[5:0], held2[5:0], s_axis_tdata[5:0]};
        endcase
      end else begin
        // stream ends inside a sequence: lead is replaced, the rest decoded again
        job.cps[0] = REPL_CP;
        if (held_count == 2'd1) begin
          job.cnt = 2'd2;
          job.cps[1] = single_cp(s_axis_tdata);
        end else if (f_h1 == FOLLOW_ONE) begin
          job.cnt = 2'd2;
          job.cps[1] = {10'b0, held1[4:0], s_axis_tdata[5:0]};
        end else begin
          job.cnt = 2'd3;
          job.cps[1] = single_cp(held1);
          job.cps[2] = single_cp(s_axis_tdata);
        end
      end
    end
  end

  assign q_push = accept && job_valid;
  assign q_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      needed_total <= 2'd0;
    end else if (accept) begin
      if (start) begin
        held_count <= 2'd1;
        needed_total <= f_in[1:0];
      end else if (finish) begin
        held_count <= 2'd0;
        needed_total <= 2'd0;
      end else if (open_seq) begin
        held_count <= held_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (start) held0 <= s_axis_tdata;
      if (open_seq && !finish && held_count == 2'd1) held1 <= s_axis_tdata;
      if (open_seq && !finish && held_count == 2'd2) held2 <= s_axis_tdata;
    end
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (needed_total == 2'd0) |-> (held_count == 2'd0))
    else $error("bytes held with no open sequence");

  a_open_count: assert property (@(posedge clk) disable iff (rst)
    (needed_total != 2'd0) |-> (held_count != 2'd0 && held_count <= needed_total))
    else $error("held count out of range for open sequence");

endmodule

// File: sv/u8u16_fifo.sv
module u8u16_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u8u16_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output u8u16_pkg::job_t head_job
);
  import u8u16_pkg::*;

  job_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_pop;

  assign full = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head_job = entries[rd_ptr];
  assign do_pop = pop && head_valid;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    logic [FIFO_PTR_W-1:0] n;
    begin
      if (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) n = '0;
      else n = p + 1'b1;
      return n;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop) rd_ptr <= ptr_inc(rd_ptr);
      if (push && !do_pop) count <= count + 1'b1;
      else if (!push && do_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("job pushed into full queue");

endmodule

// File: sv/u8u16_back.sv
module u8u16_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  u8u16_pkg::job_t               head_job,
  output logic                          pop,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [u8u16_pkg::UNIT_W-1:0]  m_axis_tdata,  // code_unit
  output logic                          m_axis_tlast,  // run_last
  output logic                          m_axis_tuser   // stream_end
);
  import u8u16_pkg::*;

  logic [IDX_W-1:0]  cp_idx;
  logic              half;
  logic [CP_W-1:0]   cp;
  logic [CP_W-1:0]   v;
  logic              big;
  logic [UNIT_W-1:0] unit;
  logic              cp_final;
  logic              job_final;
  logic              load;

  assign cp = head_job.cps[cp_idx];
  assign big = (cp[CP_W-1:UNIT_W] != '0);
  assign v = cp - SUPP_BASE;

  always_comb begin
    if (!big) unit = cp[UNIT_W-1:0];
    else if (half) unit = LO_SURR + {6'b0, v[9:0]};
    else unit = HI_SURR + {6'b0, v[19:10]};
  end

  assign cp_final = !big || half;
  assign job_final = cp_final && ({1'b0, cp_idx} + 3'd1 == {1'b0, head_job.cnt});
  assign load = head_valid && (!m_axis_tvalid || m_axis_tready);
  assign pop = load && job_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      cp_idx <= '0;
      half <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
      if (cp_final) begin
        half <= 1'b0;
        if (job_final) cp_idx <= '0;
        else cp_idx <= cp_idx + 1'b1;
      end else begin
        half <= 1'b1;
      end
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= unit;
      m_axis_tlast <= job_final;
      m_axis_tuser <= job_final && head_job.last;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> ({1'b0, cp_idx} < {1'b0, head_job.cnt}))
    else $error("unit index past end of job");

  a_half_big: assert property (@(posedge clk) disable iff (rst)
    half |-> (head_valid && big))
    else $error("low surrogate pending without supplementary code point");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("stream end on a unit that does not close its byte");

endmodule

// File: tb/utf8_to_utf16_transcoder_unit_tb.sv
module utf8_to_utf16_transcoder_unit_tb;
  import u8u16_pkg::*;

  typedef struct packed {
    logic [7:0]  b;
    logic        fin;
    logic        typed;
    logic [15:0] unit;
  } byte_row_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        run_last;
    logic        stream_end;
  } utf16_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // in_byte
  logic        s_axis_tlast = 1'b0;    // stream_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // code_unit
  logic        m_axis_tlast;           // run_last
  logic        m_axis_tuser;           // stream_end

  utf16_word_t pending_units[$];
  utf16_word_t want;
  byte_row_t   byte_plan[$];
  int          errors = 0;
  bit          calm = 1'b0;
  bit          squeeze_req = 1'b0;

  // open sequence of the predictor
  logic [7:0]  open_bytes[3];
  int          open_cnt = 0;
  int          open_need = 0;

  // rows typed with a unit are checked against that unit, the rest against the predictor
  byte_row_t directed_rows[25] = '{
    '{8'h00, 1'b0, 1'b1, 16'h0000},
    '{8'h7F, 1'b0, 1'b1, 16'h007F},
    '{8'h80, 1'b0, 1'b1, 16'hFFFD},  // stray continuation
    '{8'hF8, 1'b0, 1'b1, 16'hFFFD},  // bad lead
    '{8'hFF, 1'b1, 1'b1, 16'hFFFD},
    '{8'hC2, 1'b0, 1'b0, 16'h0000},
    '{8'hA9, 1'b0, 1'b0, 16'h0000},
    '{8'hE2, 1'b0, 1'b0, 16'h0000},
    '{8'h82, 1'b0, 1'b0, 16'h0000},
    '{8'hAC, 1'b0, 1'b0, 16'h0000},
    '{8'hF0, 1'b0, 1'b0, 16'h0000},  // surrogate pair
    '{8'h9F, 1'b0, 1'b0, 16'h0000},
    '{8'h98, 1'b0, 1'b0, 16'h0000},
    '{8'h80, 1'b0, 1'b0, 16'h0000},
    '{8'hF7, 1'b0, 1'b0, 16'h0000},  // above 10ffff, wraps
    '{8'hBF, 1'b0, 1'b0, 16'h0000},
    '{8'hBF, 1'b0, 1'b0, 16'h0000},
    '{8'hBF, 1'b0, 1'b0, 16'h0000},
    '{8'hED, 1'b0, 1'b0, 16'h0000},  // encoded surrogate passes through
    '{8'hA0, 1'b0, 1'b0, 16'h0000},
    '{8'h80, 1'b0, 1'b0, 16'h0000},
    '{8'hE0, 1'b1, 1'b1, 16'hFFFD},  // lead as final byte
    '{8'hF0, 1'b0, 1'b0, 16'h0000},  // truncated, tail decoded again
    '{8'hF0, 1'b0, 1'b0, 16'h0000},
    '{8'hF0, 1'b1, 1'b0, 16'h0000}
  };

  utf8_to_utf16_transcoder_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk = ~clk;

  function automatic logic [2:0] trail_len(input logic [7:0] c);
    logic [2:0] f;
    casez (c)
      8'b0???????: f = FOLLOW_NONE;
      8'b110?????: f = FOLLOW_ONE;
      8'b1110????: f = FOLLOW_TWO;
      8'b11110???: f = FOLLOW_THREE;
      default:     f = FOLLOW_BAD;
    endcase
    return f;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // appends one unit to the expected sequence
  task automatic add_expected(input utf16_word_t w);
    pending_units = {pending_units, w};
  endtask

  // advances the predictor by one byte and, when keep is set, queues the units it makes
  task automatic predict_units(input logic [7:0] b, input logic fin, input bit keep);
    logic [7:0]  seq[4];
    logic [15:0] cu[4];
    logic [20:0] cp;
    logic [20:0] v;
    utf16_word_t w;
    int          len;
    int          n;
    int          i;
    int          f;
    len = 0;
    n = 0;
    if (open_need != 0) begin
      if (open_cnt + 1 >= open_need + 1 || fin) begin
        for (int j = 0; j < open_cnt; j++) begin
          seq[len] = open_bytes[j];
          len++;
        end
        seq[len] = b;
        len++;
        open_cnt = 0;
        open_need = 0;
      end else begin
        open_bytes[open_cnt] = b;
        open_cnt++;
      end
    end else begin
      f = int'(trail_len(b));
      if (f >= int'(FOLLOW_ONE) && f <= int'(FOLLOW_THREE) && !fin) begin
        open_bytes[0] = b;
        open_cnt = 1;
        open_need = f;
      end else begin
        seq[0] = b;
        len = 1;
      end
    end
    i = 0;
    while (i < len && n < 4) begin
      f = int'(trail_len(seq[i]));
      if (f == int'(FOLLOW_NONE)) begin
        cp = {13'd0, seq[i]};
        i++;
      end else if (f <= int'(FOLLOW_THREE) && i + f < len) begin
        cp = {13'd0, seq[i] & (8'h7F >> (f + 1))};
        for (int k = 1; k <= f; k++) cp = (cp << 6) | {15'd0, seq[i + k][5:0]};
        i += f + 1;
      end else begin
        cp = REPL_CP;
        i++;
      end
      if (cp <= 21'h00FFFF) begin
        cu[n] = cp[15:0];
        n++;
      end else begin
        v = cp - SUPP_BASE;
        cu[n] = HI_SURR + {6'd0, v[19:10]};
        n++;
        if (n < 4) begin
          cu[n] = LO_SURR + {6'd0, v[9:0]};
          n++;
        end
      end
    end
    if (n > 3) n = 3;
    if (keep) begin
      for (int k = 0; k < n; k++) begin
        w.unit = cu[k];
        w.run_last = (k == n - 1);
        w.stream_end = (k == n - 1) && fin;
        add_expected(w);
      end
    end
  endtask

  task automatic send_item(input byte_row_t s);
    int          gap;
    utf16_word_t w;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s.b;
    s_axis_tlast  <= s.fin;
    do @(posedge clk); while (!s_axis_tready);
    if (s.typed) begin
      predict_units(s.b, s.fin, 1'b0);
      w.unit = s.unit;
      w.run_last = 1'b1;
      w.stream_end = s.fin;
      add_expected(w);
    end else begin
      predict_units(s.b, s.fin, 1'b1);
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    byte_row_t s;
    s.b = b;
    s.fin = ($urandom_range(0, 24) == 0);
    s.typed = 1'b0;
    s.unit = 16'h0000;
    byte_plan = {byte_plan, s};
  endtask

  function automatic logic [7:0] tail_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  function automatic logic [7:0] lead_of(input int need);
    case (need)
      1:       return 8'($urandom_range(8'hC0, 8'hDF));
      2:       return 8'($urandom_range(8'hE0, 8'hEF));
      default: return 8'($urandom_range(8'hF0, 8'hF7));
    endcase
  endfunction

  // mostly well-formed sequences with random payload, some noise and cut-off leads
  task automatic build_random_plan(input int target);
    int kind;
    int need;
    int tails;
    while (byte_plan.size() < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        add_byte(8'($urandom_range(8'h00, 8'h7F)));
      end else if (kind < 76) begin
        need = (kind < 40) ? 1 : (kind < 58) ? 2 : 3;
        add_byte(lead_of(need));
        repeat (need) add_byte(tail_byte());
      end else if (kind < 86) begin
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        need = $urandom_range(1, 3);
        tails = $urandom_range(0, need - 1);
        add_byte(lead_of(need));
        repeat (tails) add_byte(tail_byte());
      end
    end
    byte_plan[byte_plan.size() - 1].fin = 1'b1;
  endtask

  // receiver side: random stalls plus one long hold-off to back up the block
  initial begin
    int stall;
    bit squeezed;
    stall = 0;
    squeezed = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        m_axis_tready <= 1'b0;
        for (int c = 0; c < 120; c++) @(posedge clk);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_units.size() == 0) begin
        $display("%0t: unit with none expected: actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_units.pop_front();
        if (m_axis_tdata !== want.unit) begin
          $display("%0t: code unit: expected %h actual %h", $time, want.unit, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.run_last) begin
          $display("%0t: run_last: expected %b actual %b", $time, want.run_last,
                   m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser !== want.stream_end) begin
          $display("%0t: stream_end: expected %b actual %b", $time, want.stream_end,
                   m_axis_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i]) send_item(directed_rows[i]);
    build_random_plan(260);
    calm = 1'b1;
    squeeze_req = 1'b1;
    foreach (byte_plan[i]) begin
      if ($urandom_range(0, 19) == 0) calm = !calm;
      send_item(byte_plan[i]);
    end
    s_axis_tvalid <= 1'b0;
    wait (pending_units.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("utf8_to_utf16_transcoder_unit_tb passed");
    end else begin
      $display("utf8_to_utf16_transcoder_unit_tb failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("utf8_to_utf16_transcoder_unit_tb failed");
    $finish;
  end

endmodule
